[src/priority_queue_max_extract_defines.svh]
// ---------------------------------------------------------------------------
// Priority queue assertion macros
// Shared property shorthands for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_MAX_EXTRACT_DEFINES_SVH
`define PRIORITY_QUEUE_MAX_EXTRACT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PQME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PQME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pqme_pkg.sv]
// ---------------------------------------------------------------------------
// pqme_pkg
// Types and codes shared by the priority queue controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pqme_pkg;

	localparam int DW = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;        // request accepted: set status, clear best
		logic ins;        // write new entry at tail
		logic scan;       // read/compare pass
		logic shift_init; // point read pointer past the winner
		logic shift;      // close the gap
		logic shrink;     // drop one from the fill count
		logic load_out;   // move result into output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic rd_more;    // read pointer below fill count
		logic rd_pending; // read data in flight
		logic out_free;   // output register can take a result
	} dp_stat_t;

endpackage

`default_nettype wire

[src/pqme_ctrl.sv]
// ---------------------------------------------------------------------------
// pqme_ctrl
// Sequencer for insert, scan, compaction and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module pqme_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_cmd,
	output logic                     in_ready,
	input  wire pqme_pkg::dp_stat_t  stat,
	output pqme_pkg::ctrl_cmd_t      ctl
);

	pqme_pkg::state_t state_q, state_nxt;
	logic             pass_done;

	assign pass_done = !stat.rd_more && !stat.rd_pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqme_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pqme_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == pqme_pkg::CMD_REMOVE && !stat.empty) begin
						state_nxt = pqme_pkg::ST_SCAN;
					end else begin
						state_nxt = pqme_pkg::ST_DONE;
					end
				end
			end
			pqme_pkg::ST_SCAN: begin
				if (pass_done) state_nxt = pqme_pkg::ST_SHIFT;
			end
			pqme_pkg::ST_SHIFT: begin
				if (pass_done) state_nxt = pqme_pkg::ST_DONE;
			end
			pqme_pkg::ST_DONE: begin
				if (stat.out_free) state_nxt = pqme_pkg::ST_IDLE;
			end
			default: state_nxt = pqme_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			pqme_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ctl.cap  = in_valid;
				ctl.ins  = in_valid && (in_cmd == pqme_pkg::CMD_INSERT) && !stat.full;
			end
			pqme_pkg::ST_SCAN: begin
				ctl.scan       = !pass_done;
				ctl.shift_init = pass_done;
			end
			pqme_pkg::ST_SHIFT: begin
				ctl.shift  = !pass_done;
				ctl.shrink = pass_done;
			end
			pqme_pkg::ST_DONE: begin
				ctl.load_out = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/pqme_datapath.sv]
// ---------------------------------------------------------------------------
// pqme_datapath
// Entry memory, fill count, scan/compare unit and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pqme_datapath #(
	parameter int CAPACITY = 128
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pqme_pkg::ctrl_cmd_t        ctl,
	output pqme_pkg::dp_stat_t              stat,
	input  wire logic                       in_cmd,
	input  wire logic [pqme_pkg::DW-1:0]    in_value,
	input  wire logic [pqme_pkg::DW-1:0]    in_rank,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      status,
	output logic [pqme_pkg::DW-1:0]         removed_value,
	output logic [pqme_pkg::DW-1:0]         removed_rank
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = pqme_pkg::DW;

	// entry = {rank, value}
	logic [2*DW-1:0] mem_q [CAPACITY];
	logic [2*DW-1:0] rd_data_s1;
	logic            rd_vld_s1;
	logic [AW-1:0]   rd_idx_s1;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   ptr_q;
	logic [AW-1:0]   best_idx_q;
	logic [DW-1:0]   best_val_q;
	logic [DW-1:0]   best_rank_q;
	logic [1:0]      res_status_q;

	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic [DW-1:0]   out_value_q;
	logic [DW-1:0]   out_rank_q;

	logic            rd_en;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [2*DW-1:0] wr_data;
	logic            take_best;

	assign stat.full       = (cnt_q == CW'(CAPACITY));
	assign stat.empty      = (cnt_q == '0);
	assign stat.rd_more    = (ptr_q < cnt_q);
	assign stat.rd_pending = rd_vld_s1;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign rd_en   = (ctl.scan || ctl.shift) && stat.rd_more;
	assign wr_en   = ctl.ins || (ctl.shift && rd_vld_s1);
	assign wr_addr = ctl.ins ? cnt_q[AW-1:0] : rd_idx_s1 - AW'(1);
	assign wr_data = ctl.ins ? {in_rank, in_value} : rd_data_s1;

	// strict greater-than keeps the oldest of equal ranks
	assign take_best = ctl.scan && rd_vld_s1 &&
		((rd_idx_s1 == '0) ||
		 ($signed(rd_data_s1[2*DW-1:DW]) > $signed(best_rank_q)));

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_s1 <= mem_q[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) rd_idx_s1 <= ptr_q[AW-1:0];

			if (ctl.cap) begin
				ptr_q <= '0;
			end else if (ctl.shift_init) begin
				ptr_q <= CW'(best_idx_q) + CW'(1);
			end else if (rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end

			if (ctl.ins) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.shrink) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			best_val_q  <= '0;
			best_rank_q <= '0;
			best_idx_q  <= '0;
			if (in_cmd == pqme_pkg::CMD_INSERT) begin
				res_status_q <= stat.full ? pqme_pkg::STATUS_OVERFLOW : pqme_pkg::STATUS_OK;
			end else begin
				res_status_q <= stat.empty ? pqme_pkg::STATUS_UNDERFLOW : pqme_pkg::STATUS_OK;
			end
		end else if (take_best) begin
			best_idx_q  <= rd_idx_s1;
			best_val_q  <= rd_data_s1[DW-1:0];
			best_rank_q <= rd_data_s1[2*DW-1:DW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= best_val_q;
			out_rank_q   <= best_rank_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_value = out_value_q;
	assign removed_rank  = out_rank_q;

endmodule

`default_nettype wire

[src/priority_queue_max_extract.sv]
// ---------------------------------------------------------------------------
// priority_queue_max_extract
// Bounded max-priority queue with FIFO order among equal priorities.
// ---------------------------------------------------------------------------
// Each request either inserts an (item_value, item_rank) pair or removes the
// entry with the largest signed item_rank; among equal ranks the oldest entry
// leaves first. Every request returns one result: status OK, OVERFLOW (insert
// into a full queue, dropped) or UNDERFLOW (remove from an empty queue); the
// removed_value/removed_rank fields carry the removed entry and are zero for
// anything else. One request is in work at a time. An insert or an error
// request goes from idle straight to the done state; a remove with entries
// stored first scans every stored entry, oldest first, for the winner, then
// compacts the newer entries behind it. In the done state the result moves
// into the output register once that register is free, and the block then
// returns to idle to take the next request. Entries live in a single-read,
// single-write memory, so the scan reads one entry per cycle and the
// compaction behind the winner moves one entry per cycle. The result sits in
// an output register, so a stalled consumer only holds the block once the
// next result is ready. No clearing pass after reset: only entries below the
// fill count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_queue_max_extract #(
	parameter int CAPACITY = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// request channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                cmd,
	input  wire logic signed [31:0]  item_value,
	input  wire logic signed [31:0]  item_rank,

	// result channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               status,
	output logic signed [31:0]       removed_value,
	output logic signed [31:0]       removed_rank
);

	pqme_pkg::ctrl_cmd_t ctl;
	pqme_pkg::dp_stat_t  stat;

	logic [pqme_pkg::DW-1:0] dp_value;
	logic [pqme_pkg::DW-1:0] dp_rank;

	// sequencer: idle -> scan -> shift -> done, or idle -> done
	pqme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// entry memory, fill count, compare unit, output register
	pqme_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.in_cmd        (cmd),
		.in_value      (item_value),
		.in_rank       (item_rank),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.removed_value (dp_value),
		.removed_rank  (dp_rank)
	);

	assign removed_value = $signed(dp_value);
	assign removed_rank  = $signed(dp_rank);

endmodule

`default_nettype wire

[src/pqme_checker.sv]
// ---------------------------------------------------------------------------
// pqme_checker
// Port-level checks for the priority queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "priority_queue_max_extract_defines.svh"

module pqme_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  status,
	input  wire logic [31:0] removed_value,
	input  wire logic [31:0] removed_rank
);

	// held result stays put
	`PQME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(removed_value) && $stable(removed_rank), "result changed while stalled")

	// one request in work at a time
	`PQME_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "request taken while busy")

	// only defined status codes
	`PQME_ASSERT_NOW(a_status_code, out_valid, status == pqme_pkg::STATUS_OK || status == pqme_pkg::STATUS_OVERFLOW || status == pqme_pkg::STATUS_UNDERFLOW, "undefined status code")

	// failed requests carry no entry
	`PQME_ASSERT_NOW(a_err_zero, out_valid && status != pqme_pkg::STATUS_OK, removed_value == '0 && removed_rank == '0, "error result with payload")

endmodule

bind priority_queue_max_extract pqme_checker u_pqme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.removed_value (removed_value),
	.removed_rank  (removed_rank)
);

`default_nettype wire

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// priority_queue_max_extract testbench
// Drives insert and remove requests through the valid/ready request channel,
// predicts unpinned results with a shadow queue and compares each result field.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PQ_DEPTH      = 128;
	localparam int TOTAL_REQ     = 550;  // stop sending after this many requests
	localparam int QUIET_FROM    = 490;  // no idling on either side from here on
	localparam int MIX_LEAD      = 60;   // mixed traffic before the fill phase
	localparam int OVERFLOW_GOAL = 6;    // dropped inserts to see while full
	localparam int UNDERFLOW_ADD = 4;    // empty removes to see after draining
	localparam int HOLD_CYCLES   = 64;   // long receiver hold-off
	localparam int DRAIN_CYCLES  = 300;  // quiet time after the last result

	// one result as the block reports it
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic signed [31:0] rank;
	} pq_result_t;

	// one directed request; pinned rows carry a hand-written result
	typedef struct packed {
		logic               op;
		logic signed [31:0] value;
		logic signed [31:0] rank;
		bit                 pinned;
		pq_result_t         result;
	} pq_row_t;

	typedef enum {
		MODE_MIX,   // even split of inserts and removes
		MODE_FILL,  // mostly inserts, runs the queue into overflow
		MODE_DRAIN  // mostly removes, runs the queue into underflow
	} traffic_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = pqme_pkg::CMD_INSERT;
	logic signed [31:0] item_value = '0;
	logic signed [31:0] item_rank = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic signed [31:0] removed_rank;

	// shadow of the stored entries, oldest first
	logic signed [31:0] shadow_values[$];
	logic signed [31:0] shadow_ranks[$];
	// results the block still owes, oldest first
	pq_result_t         results_due[$];

	int  errors = 0;
	int  sent_count = 0;
	int  results_checked = 0;
	int  overflow_hits = 0;
	int  underflow_hits = 0;
	bit  quiet_tail = 1'b0;

	// Directed requests: extremes of data and rank, both error codes, and the
	// tie rule (equal ranks leave oldest first, the rest keep their order).
	pq_row_t directed_rows [0:20] = '{
		// remove on an empty queue right after reset, junk in ignored fields
		'{pqme_pkg::CMD_REMOVE, 32'hDEADBEEF, 32'h12345678, 1'b1,
			'{pqme_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0}},
		// extreme data and ranks; a good insert returns zeros
		'{pqme_pkg::CMD_INSERT, 32'h7FFFFFFF, 32'h80000000, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'h0, 32'h0}},
		'{pqme_pkg::CMD_INSERT, 32'h80000000, 32'h7FFFFFFF, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'h0, 32'h0}},
		'{pqme_pkg::CMD_INSERT, 32'h00000000, 32'h00000000, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'h0, 32'h0}},
		'{pqme_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'h0, 32'h0}},
		// signed order: max, zero, minus one, min
		'{pqme_pkg::CMD_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'h80000000, 32'h7FFFFFFF}},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'h0, 32'h0}},
		'{pqme_pkg::CMD_REMOVE, 32'h5A5A5A5A, 32'hA5A5A5A5, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'hFFFFFFFF, 32'hFFFFFFFF}},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b1,
			'{pqme_pkg::STATUS_OK, 32'h7FFFFFFF, 32'h80000000}},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b1,
			'{pqme_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0}},
		// ties on rank 5, one lower entry, a later higher one
		'{pqme_pkg::CMD_INSERT, 32'd11, 32'd5, 1'b0, '0},
		'{pqme_pkg::CMD_INSERT, 32'd22, 32'd5, 1'b0, '0},
		'{pqme_pkg::CMD_INSERT, 32'd33, -32'sd3, 1'b0, '0},
		'{pqme_pkg::CMD_INSERT, 32'd44, 32'd5, 1'b0, '0},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
		'{pqme_pkg::CMD_INSERT, 32'd55, 32'd6, 1'b0, '0},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
		'{pqme_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b1,
			'{pqme_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0}}
	};

	priority_queue_max_extract #(
		.CAPACITY(PQ_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.item_value   (item_value),
		.item_rank    (item_rank),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.removed_value(removed_value),
		.removed_rank (removed_rank)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one accepted request to the shadow queue and return its result.
	// Removal scans oldest first with a strict signed compare, so the first
	// of several equal ranks wins; deleting from the queue keeps the order.
	function automatic pq_result_t apply_to_shadow(input logic op,
			input logic signed [31:0] value, input logic signed [31:0] rank);
		pq_result_t res;
		int         best;
		res = '{pqme_pkg::STATUS_OK, 32'sd0, 32'sd0};
		if (op == pqme_pkg::CMD_INSERT) begin
			if (shadow_values.size() >= PQ_DEPTH) begin
				res.status = pqme_pkg::STATUS_OVERFLOW;
			end else begin
				shadow_values.push_back(value);
				shadow_ranks.push_back(rank);
			end
		end else if (shadow_values.size() == 0) begin
			res.status = pqme_pkg::STATUS_UNDERFLOW;
		end else begin
			best = 0;
			for (int i = 1; i < shadow_ranks.size(); i++)
				if (shadow_ranks[i] > shadow_ranks[best])
					best = i;
			res.value = shadow_values[best];
			res.rank  = shadow_ranks[best];
			shadow_values.delete(best);
			shadow_ranks.delete(best);
		end
		return res;
	endfunction

	// Offer one request and hold it until accepted. Called at a rising edge;
	// returns at the edge of acceptance, so the caller may drive the next
	// request in the same step without touching in_valid twice.
	task automatic send_request(input logic op, input logic signed [31:0] value,
			input logic signed [31:0] rank, input bit pinned, input pq_result_t pinned_res);
		pq_result_t res;
		in_valid   <= 1'b1;
		cmd        <= op;
		item_value <= value;
		item_rank  <= rank;
		do
			@(posedge clk);
		while (!in_ready);
		res = apply_to_shadow(op, value, rank);
		if (res.status == pqme_pkg::STATUS_OVERFLOW)
			overflow_hits++;
		if (res.status == pqme_pkg::STATUS_UNDERFLOW)
			underflow_hits++;
		results_due.push_back(pinned ? pinned_res : res);
		sent_count++;
		if (sent_count >= QUIET_FROM)
			quiet_tail = 1'b1;
	endtask

	// Idle the request side for a short random burst now and then.
	task automatic maybe_idle_sender();
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// One random request shaped by the traffic mode. Ranks lean on a narrow
	// band so ties are common, with full-range and extreme ranks mixed in.
	task automatic issue_random(input traffic_mode_t mode);
		logic               op;
		logic signed [31:0] rank;
		case (mode)
			MODE_FILL:  op = ($urandom_range(0, 9) != 0) ? pqme_pkg::CMD_INSERT
				: pqme_pkg::CMD_REMOVE;
			MODE_DRAIN: op = ($urandom_range(0, 9) != 0) ? pqme_pkg::CMD_REMOVE
				: pqme_pkg::CMD_INSERT;
			default:    op = $urandom_range(0, 1) ? pqme_pkg::CMD_REMOVE
				: pqme_pkg::CMD_INSERT;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3: rank = $urandom;
			4, 5, 6, 7: rank = $signed($urandom_range(0, 7)) - 32'sd4;
			8:          rank = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default:    rank = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
		endcase
		send_request(op, $urandom, rank, 1'b0, '0);
		maybe_idle_sender();
	endtask

	// request side: reset, directed table, random phases, end of run
	initial begin
		int underflow_base;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].rank,
				directed_rows[i].pinned, directed_rows[i].result);
			maybe_idle_sender();
		end

		repeat (MIX_LEAD) issue_random(MODE_MIX);

		// run the queue full and keep pushing until inserts get dropped
		while (overflow_hits < OVERFLOW_GOAL)
			issue_random(MODE_FILL);

		// empty it again and try a few removes on nothing
		underflow_base = underflow_hits;
		while (underflow_hits < underflow_base + UNDERFLOW_ADD)
			issue_random(MODE_DRAIN);

		// sender holds off until the block has returned everything
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);

		while (sent_count < TOTAL_REQ)
			issue_random(MODE_MIX);

		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		// room for a stray result to show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[priority_queue_max_extract] OK");
		else
			$display("[priority_queue_max_extract] ERROR");
		$finish;
	end

	// result side: check every accepted result against the oldest one due,
	// then pick out_ready for the next cycle
	initial begin
		pq_result_t want;
		int         stall_left;
		int         hold_left;
		stall_left = 0;
		hold_left  = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: result with none due: status %0d value %0d rank %0d",
						$time, status, removed_value, removed_rank);
				end else begin
					want = results_due.pop_front();
					if (status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
					end
					if (removed_value !== want.value) begin
						errors++;
						$display("%0t: removed_value expected %0d actual %0d",
							$time, want.value, removed_value);
					end
					if (removed_rank !== want.rank) begin
						errors++;
						$display("%0t: removed_rank expected %0d actual %0d",
							$time, want.rank, removed_rank);
					end
				end
				results_checked++;
				// long hold-off while the sender keeps offering: block backs up
				if (results_checked == 90 || results_checked == 330)
					hold_left = HOLD_CYCLES;
			end

			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: far beyond the slowest legal run (every remove on a full
	// queue, every stall at its longest).
	initial begin
		#10_000_000;
		$display("[priority_queue_max_extract] ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/pqme_pkg.sv
src/pqme_ctrl.sv
src/pqme_datapath.sv
src/priority_queue_max_extract.sv
src/pqme_checker.sv
sim/testbench.sv
